[sv/rtsd_pkg.sv]
package rtsd_pkg;

    localparam int IN_W   = 18;
    localparam int SPD_W  = 17;
    localparam int DIST_W = 32;
    localparam int ACC_W  = 64;

    // quotient bits of the acceleration-time divide; |ta| < 2^19 for every legal input
    localparam int QB = 19;

    // speed word width plus fraction bits stays constant over the fraction range
    localparam int SW_FRAC_SUM = 40;

    // register stages inside one phase unit
    localparam int PH_LAT = QB + 8;

    localparam int SPEED_MAX = 131071;
    localparam logic signed [ACC_W-1:0] DIST_MAX = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] DIST_MIN = -64'sd2147483648;

    typedef struct packed {
        logic                   valid;
        logic                   err;
        logic [IN_W-1:0]        t1;
        logic signed [IN_W-1:0] v0;
        logic [IN_W-1:0]        t2;
        logic [SPD_W-1:0]       lim;
        logic                   lim_ok;
        logic signed [IN_W-1:0] a1;
        logic signed [IN_W-1:0] a2;
    } t_stage0;

    typedef struct packed {
        logic                   valid;
        logic                   err;
        logic [IN_W-1:0]        t2;
        logic signed [IN_W-1:0] a2;
        logic [SPD_W-1:0]       lim;
        logic                   lim_ok;
    } t_side1;

    typedef struct packed {
        logic                    valid;
        logic                    err;
        logic signed [ACC_W-1:0] d1;
    } t_side2;

endpackage

[sv/rtsd_phase.sv]
module rtsd_phase
    import rtsd_pkg::*;
#(
    parameter int FRAC_BITS = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [SW_FRAC_SUM-FRAC_BITS-1:0] i_v0,
    input  logic signed [IN_W-1:0]                 i_a,
    input  logic [IN_W-1:0]                        i_t,
    input  logic [SPD_W-1:0]                       i_lim,
    input  logic                                   i_lim_ok,
    output logic signed [SW_FRAC_SUM-FRAC_BITS-1:0] o_v,
    output logic signed [ACC_W-1:0]                o_d
);

    localparam int SW  = SW_FRAC_SUM - FRAC_BITS;
    localparam int NW  = SW + FRAC_BITS + 1;
    localparam int MW  = 2 * IN_W + 1;
    localparam int TAW = QB + 1;
    localparam int TMW = TAW + 1;

    localparam logic signed [MW-1:0]    HALF_M = MW'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_D = ACC_W'(1) << (2 * FRAC_BITS);

    typedef struct packed {
        logic signed [SW-1:0]   v0;
        logic signed [IN_W-1:0] a;
        logic [IN_W-1:0]        t;
        logic signed [SW-1:0]   v;
        logic signed [SW:0]     dv;
        logic                   neg;
        logic                   azero;
    } t_pass;

    // stage 1: a*t
    logic signed [SW-1:0]   r1_v0;
    logic signed [IN_W-1:0] r1_a;
    logic [IN_W-1:0]        r1_t;
    logic [SPD_W-1:0]       r1_lim;
    logic                   r1_lim_ok;
    logic signed [MW-1:0]   r1_m;
    logic signed [MW-1:0]   n1_m;

    assign n1_m = i_a * $signed({1'b0, i_t});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v0     <= i_v0;
            r1_a      <= i_a;
            r1_t      <= i_t;
            r1_lim    <= i_lim;
            r1_lim_ok <= i_lim_ok;
            r1_m      <= n1_m;
        end
    end

    // stage 2: rounded speed change, speed cap
    logic signed [SW-1:0]   r2_v0;
    logic signed [IN_W-1:0] r2_a;
    logic [IN_W-1:0]        r2_t;
    logic                   r2_lim_ok;
    logic signed [SW:0]     r2_vraw;
    logic signed [SW-1:0]   r2_cap;
    logic signed [MW-1:0]   n2_r;
    logic signed [SW:0]     n2_vraw;
    logic signed [SW-1:0]   n2_lim;
    logic signed [SW-1:0]   n2_cap;

    always_comb begin
        n2_r    = (r1_m + HALF_M) >>> FRAC_BITS;
        n2_vraw = (SW+1)'(r1_v0) + (SW+1)'(n2_r);
        n2_lim  = SW'($signed({1'b0, r1_lim}));
        n2_cap  = (n2_lim > r1_v0) ? n2_lim : r1_v0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_v0     <= r1_v0;
            r2_a      <= r1_a;
            r2_t      <= r1_t;
            r2_lim_ok <= r1_lim_ok;
            r2_vraw   <= n2_vraw;
            r2_cap    <= n2_cap;
        end
    end

    // stage 3: clamp, divider operands
    logic signed [SW-1:0] n3_v;
    logic signed [SW:0]   n3_dv;
    logic [SW:0]          n3_dvmag;
    logic [IN_W-1:0]      n3_den;
    t_pass                n3_p;

    always_comb begin
        if (r2_vraw < 0) begin
            n3_v = '0;
        end else if (r2_lim_ok && (r2_vraw > r2_cap)) begin
            n3_v = r2_cap;
        end else begin
            n3_v = SW'(r2_vraw);
        end
        n3_dv    = (SW+1)'(n3_v) - (SW+1)'(r2_v0);
        n3_dvmag = n3_dv[SW] ? $unsigned(-n3_dv) : $unsigned(n3_dv);
        n3_den   = r2_a[IN_W-1] ? $unsigned(-r2_a) : $unsigned(r2_a);
        n3_p.v0    = r2_v0;
        n3_p.a     = r2_a;
        n3_p.t     = r2_t;
        n3_p.v     = n3_v;
        n3_p.dv    = n3_dv;
        n3_p.neg   = n3_dv[SW] ^ r2_a[IN_W-1];
        n3_p.azero = (r2_a == '0);
    end

    // restoring divide, one quotient bit per stage, msb first
    logic [NW-1:0]   r_rem [0:QB-1];
    logic [IN_W-1:0] r_den [0:QB-1];
    logic [QB-1:0]   r_q   [1:QB];
    t_pass           r_p   [0:QB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= NW'(n3_dvmag) << FRAC_BITS;
            r_den[0] <= n3_den;
            r_p[0]   <= n3_p;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [NW-1:0] n_sub;
        logic          n_ge;
        logic [QB-1:0] n_qin;

        assign n_sub = NW'(r_den[k]) << (QB - 1 - k);
        assign n_ge  = (r_rem[k] >= n_sub);

        if (k == 0) begin : g_first
            assign n_qin = '0;
        end else begin : g_rest
            assign n_qin = r_q[k];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1] <= {n_qin[QB-2:0], n_ge};
                r_p[k+1] <= r_p[k];
            end
        end

        if (k < QB - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_ge ? (r_rem[k] - n_sub) : r_rem[k];
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    // acceleration time and remaining time
    logic signed [SW-1:0]   r4_v0;
    logic signed [IN_W-1:0] r4_a;
    logic [IN_W-1:0]        r4_t;
    logic signed [SW-1:0]   r4_v;
    logic signed [SW:0]     r4_dv;
    logic signed [TAW-1:0]  r4_ta;
    logic signed [TMW-1:0]  r4_tmt;
    logic signed [TAW-1:0]  n4_q;
    logic signed [TAW-1:0]  n4_ta;

    always_comb begin
        n4_q = $signed({1'b0, r_q[QB]});
        if (r_p[QB].azero) begin
            n4_ta = '0;
        end else if (r_p[QB].neg) begin
            n4_ta = -n4_q;
        end else begin
            n4_ta = n4_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_v0  <= r_p[QB].v0;
            r4_a   <= r_p[QB].a;
            r4_t   <= r_p[QB].t;
            r4_v   <= r_p[QB].v;
            r4_dv  <= r_p[QB].dv;
            r4_ta  <= n4_ta;
            r4_tmt <= TMW'($signed({1'b0, r_p[QB].t})) - TMW'(n4_ta);
        end
    end

    // products
    logic signed [SW+IN_W:0]     r5_p1;
    logic signed [IN_W+TAW-1:0]  r5_p2;
    logic signed [SW+TMW:0]      r5_p3;
    logic signed [TAW-1:0]       r5_ta;
    logic signed [SW-1:0]        r5_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_p1 <= r4_v0 * $signed({1'b0, r4_t});
            r5_p2 <= r4_a * r4_ta;
            r5_p3 <= r4_dv * r4_tmt;
            r5_ta <= r4_ta;
            r5_v  <= r4_v;
        end
    end

    logic signed [IN_W+2*TAW-1:0] r6_p4;
    logic signed [ACC_W-1:0]      r6_s;
    logic signed [SW-1:0]         r6_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_p4 <= r5_p2 * r5_ta;
            r6_s  <= ACC_W'(r5_p1) + ACC_W'(r5_p3);
            r6_v  <= r5_v;
        end
    end

    // distance with 2*frac+1 extra fraction bits
    logic signed [ACC_W-1:0] r7_acc;
    logic signed [SW-1:0]    r7_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_acc <= (r6_s <<< (FRAC_BITS + 1)) + ACC_W'(r6_p4);
            r7_v   <= r6_v;
        end
    end

    logic signed [ACC_W-1:0] r8_d;
    logic signed [SW-1:0]    r8_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_d <= (r7_acc + HALF_D) >>> (2 * FRAC_BITS + 1);
            r8_v <= r7_v;
        end
    end

    assign o_v = r8_v;
    assign o_d = r8_d;

endmodule

[sv/response_time_speed_distance.sv]
// Two-phase speed and distance predictor: for each query it runs the first
// acceleration up to the response time and the second one for the rest of the
// duration, clamping speed at zero and at the optional limit. One query is taken
// every cycle while the output is not stalled; a query passes through the input
// register, the two phase units in series, each holding a 19-stage restoring
// divider for the acceleration time, and the output register. A stall on the
// output freezes the whole pipeline. Negative duration, start speed or response
// time returns ok low with zero fields; the distance saturates to 32 bits.
module response_time_speed_distance
    import rtsd_pkg::*;
#(
    parameter int FRAC_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [IN_W-1:0]   i_duration,
    input  logic signed [IN_W-1:0]   i_start_speed,
    input  logic signed [IN_W-1:0]   i_response_time,
    input  logic [SPD_W-1:0]         i_speed_limit,
    input  logic                     i_speed_limit_valid,
    input  logic signed [IN_W-1:0]   i_accel_before,
    input  logic signed [IN_W-1:0]   i_accel_after,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [SPD_W-1:0]         o_end_speed,
    output logic signed [DIST_W-1:0] o_distance,
    output logic                     o_ok,
    output logic                     o_saturated
);

    localparam int SW = SW_FRAC_SUM - FRAC_BITS;

    logic en;
    logic r_out_valid;

    assign o_stall = r_out_valid & i_stall;
    assign en      = ~o_stall;

    // input stage
    t_stage0                r0;
    t_stage0                n0;
    logic signed [IN_W-1:0] n0_t1;
    logic signed [IN_W:0]   n0_diff;

    always_comb begin
        n0_t1   = (i_duration < i_response_time) ? i_duration : i_response_time;
        n0_diff = (IN_W+1)'(i_duration) - (IN_W+1)'(i_response_time);
        n0.valid  = i_valid;
        n0.err    = n0_t1[IN_W-1] | i_start_speed[IN_W-1];
        n0.t1     = $unsigned(n0_t1);
        n0.v0     = i_start_speed;
        // no second phase gives zero time, which leaves speed and distance unchanged
        n0.t2     = (i_duration > i_response_time) ? n0_diff[IN_W-1:0] : '0;
        n0.lim    = i_speed_limit;
        n0.lim_ok = i_speed_limit_valid;
        n0.a1     = i_accel_before;
        n0.a2     = i_accel_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0.valid <= 1'b0;
        end else if (en) begin
            r0 <= n0;
        end
    end

    // phase one
    logic signed [SW-1:0]    ph1_v;
    logic signed [ACC_W-1:0] ph1_d;

    rtsd_phase #(
        .FRAC_BITS (FRAC_BITS)
    ) u_phase1 (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_v0     (SW'(r0.v0)),
        .i_a      (r0.a1),
        .i_t      (r0.t1),
        .i_lim    (r0.lim),
        .i_lim_ok (r0.lim_ok),
        .o_v      (ph1_v),
        .o_d      (ph1_d)
    );

    t_side1 r_s1 [0:PH_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PH_LAT; k++) begin
                r_s1[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_s1[0] <= '{valid: r0.valid, err: r0.err, t2: r0.t2, a2: r0.a2,
                         lim: r0.lim, lim_ok: r0.lim_ok};
            for (int k = 1; k < PH_LAT; k++) begin
                r_s1[k] <= r_s1[k-1];
            end
        end
    end

    // phase two
    logic signed [SW-1:0]    ph2_v;
    logic signed [ACC_W-1:0] ph2_d;

    rtsd_phase #(
        .FRAC_BITS (FRAC_BITS)
    ) u_phase2 (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_v0     (ph1_v),
        .i_a      (r_s1[PH_LAT-1].a2),
        .i_t      (r_s1[PH_LAT-1].t2),
        .i_lim    (r_s1[PH_LAT-1].lim),
        .i_lim_ok (r_s1[PH_LAT-1].lim_ok),
        .o_v      (ph2_v),
        .o_d      (ph2_d)
    );

    t_side2 r_s2 [0:PH_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PH_LAT; k++) begin
                r_s2[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_s2[0] <= '{valid: r_s1[PH_LAT-1].valid, err: r_s1[PH_LAT-1].err, d1: ph1_d};
            for (int k = 1; k < PH_LAT; k++) begin
                r_s2[k] <= r_s2[k-1];
            end
        end
    end

    // sum, saturate, output register
    logic signed [ACC_W-1:0]  n_sum;
    logic                     n_hi;
    logic                     n_lo;
    logic [SPD_W-1:0]         n_speed;
    logic [SPD_W-1:0]         r_end_speed;
    logic signed [DIST_W-1:0] r_distance;
    logic                     r_ok;
    logic                     r_saturated;
    logic                     n_err;

    always_comb begin
        n_err   = r_s2[PH_LAT-1].err;
        n_sum   = r_s2[PH_LAT-1].d1 + ph2_d;
        n_hi    = n_sum > DIST_MAX;
        n_lo    = n_sum < DIST_MIN;
        n_speed = (ph2_v > SW'(SPEED_MAX)) ? SPD_W'(SPEED_MAX) : ph2_v[SPD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2[PH_LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok <= ~n_err;
            if (n_err) begin
                r_end_speed <= '0;
                r_distance  <= '0;
                r_saturated <= 1'b0;
            end else begin
                r_end_speed <= n_speed;
                priority if (n_hi) begin
                    r_distance <= DIST_MAX[DIST_W-1:0];
                end else if (n_lo) begin
                    r_distance <= DIST_MIN[DIST_W-1:0];
                end else begin
                    r_distance <= n_sum[DIST_W-1:0];
                end
                r_saturated <= n_hi | n_lo;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_end_speed = r_end_speed;
    assign o_distance  = r_distance;
    assign o_ok        = r_ok;
    assign o_saturated = r_saturated;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_end_speed == '0 && o_distance == '0 && !o_saturated))
        else $error("error result carries nonzero fields");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
        (o_distance == 32'sh7fffffff || o_distance == 32'sh80000000))
        else $error("saturated distance is not at a rail");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output stage is empty");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
